>>> hdl/mbg_pkg.sv
// ============================================================================
// mbg_pkg: shared types and helpers for the maze backtracker generator
// Item and result payloads, configuration layout, sequencer states and
// the small combinational helpers used by the carving engine.
// ============================================================================
package mbg_pkg;

    // Operation codes carried by an input beat.
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STEP  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Carve directions, also the order in which neighbours are listed.
    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    // Configuration register indexes (byte address 4*index).
    localparam int          PADDR_W         = 3;
    localparam logic [0:0]  REG_MAZE_WIDTH  = 1'b0;
    localparam logic [0:0]  REG_MAZE_HEIGHT = 1'b1;
    localparam logic [6:0]  SIZE_RESET      = 7'd16;

    // Wall bits inside a cell word.
    localparam logic [3:0]  WALLS_ALL  = 4'hF;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] random_value;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
    } in_item_t;

    typedef struct packed {
        logic        carved;
        logic [5:0]  from_x;
        logic [5:0]  from_y;
        logic [1:0]  direction;
        logic        done_res;
        logic [3:0]  walls;
        logic        cell_visited;
    } out_item_t;

    typedef struct packed {
        logic [6:0] maze_width;
        logic [6:0] maze_height;
    } cfg_t;

    typedef struct packed {
        logic       visited;
        logic [3:0] walls;
    } cell_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RDWAIT,
        ST_TOP,
        ST_PROBE,
        ST_LAST,
        ST_DECIDE,
        ST_WTOP,
        ST_FIN_A,
        ST_FIN_B,
        ST_FIN_C,
        ST_RESP
    } state_t;

    // Remainder of a 16-bit value by three. Since 4 is 1 modulo 3, the sum of
    // the base-4 digits has the same remainder; two folds bring it below 6.
    function automatic logic [1:0] mod3_16(input logic [15:0] v);
        logic [4:0] s;
        logic [3:0] s2;
        logic [2:0] s3;
        s = '0;
        for (int i = 0; i < 8; i++)
        begin
            s = s + {3'b000, v[2*i +: 2]};
        end
        s2 = {1'b0, s[4:2]} + {2'b00, s[1:0]};
        s3 = {1'b0, s2[3:2]} + {1'b0, s2[1:0]};
        if (s3 >= 3'd3)
        begin
            s3 = s3 - 3'd3;
        end
        return s3[1:0];
    endfunction

    // Position of the n-th set bit of a four-bit candidate mask.
    function automatic dir_t nth_set(input logic [3:0] mask, input logic [1:0] n);
        logic [1:0] seen;
        dir_t       pos;
        seen = '0;
        pos  = DIR_UP;
        for (int i = 0; i < 4; i++)
        begin
            if (mask[i])
            begin
                if (seen == n)
                begin
                    pos = dir_t'(2'(i));
                end
                seen = seen + 2'd1;
            end
        end
        return pos;
    endfunction

    // Wall bit of a cell that faces the given direction.
    function automatic logic [3:0] wall_bit(input dir_t d);
        logic [3:0] b;
        case (d)
            DIR_UP:    b = 4'b0001;
            DIR_DOWN:  b = 4'b0010;
            DIR_LEFT:  b = 4'b0100;
            DIR_RIGHT: b = 4'b1000;
            default:   b = 4'b0000;
        endcase
        return b;
    endfunction

    function automatic dir_t opposite(input dir_t d);
        dir_t o;
        case (d)
            DIR_UP:    o = DIR_DOWN;
            DIR_DOWN:  o = DIR_UP;
            DIR_LEFT:  o = DIR_RIGHT;
            DIR_RIGHT: o = DIR_LEFT;
            default:   o = DIR_UP;
        endcase
        return o;
    endfunction

endpackage

>>> hdl/mbg_ram.sv
// ============================================================================
// mbg_ram: simple dual-port synchronous memory
// One write port and one read port; read data is registered.
// ============================================================================
module mbg_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/mbg_engine.sv
// ============================================================================
// mbg_engine: carving sequencer around the cell store and the path stack
// Reads the stack top, probes the four neighbours in the cell store, pops
// dead ends, carves one passage per step and makes the final opening.
// ============================================================================
module mbg_engine #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mbg_pkg::cfg_t      cfg,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  mbg_pkg::in_item_t  cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output mbg_pkg::out_item_t res
);
    import mbg_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int SW    = XW + YW;
    localparam int CWD   = $bits(cell_word_t);

    localparam logic [AW-1:0] START_ADDR = AW'(MAX_WIDTH);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(CELLS - 1);

    function automatic logic [AW-1:0] cell_addr(input int unsigned x, input int unsigned y);
        return AW'(y * MAX_WIDTH + x);
    endfunction

    // Registers
    state_t              state_reg,      state_next;
    logic [AW-1:0]       clr_addr_reg,   clr_addr_next;
    logic                clr_start_reg,  clr_start_next;
    logic [CW-1:0]       count_reg,      count_next;
    logic                finished_reg,   finished_next;
    logic [1:0]          probe_reg,      probe_next;
    logic [15:0]         rnd_reg,        rnd_next;
    logic [1:0]          rnd_m3_reg,     rnd_m3_next;
    logic [XW-1:0]       top_x_reg,      top_x_next;
    logic [YW-1:0]       top_y_reg,      top_y_next;
    cell_word_t          top_word_reg,   top_word_next;
    cell_word_t          nb_word_reg  [4];
    cell_word_t          nb_word_next [4];
    dir_t                dir_reg,        dir_next;
    out_item_t           res_reg,        res_next;

    // Memory ports
    logic                cell_we, cell_re;
    logic [AW-1:0]       cell_waddr, cell_raddr;
    cell_word_t          cell_wdata, cell_rdata;
    logic                stk_we, stk_re;
    logic [AW-1:0]       stk_waddr, stk_raddr;
    logic [SW-1:0]       stk_wdata, stk_rdata;

    // Working values
    logic [WW-1:0]       w;
    logic [HW-1:0]       h;
    logic [XW-1:0]       nbx [4];
    logic [YW-1:0]       nby [4];
    logic [3:0]          inb;
    logic [3:0]          cand;
    logic [2:0]          cand_n;
    logic [1:0]          pick;
    dir_t                pick_dir;
    logic [CW-1:0]       cnt_m1, cnt_m2;

    mbg_ram #(
        .WIDTH (CWD),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .re    (cell_re),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    mbg_ram #(
        .WIDTH (SW),
        .DEPTH (CELLS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Sizes in effect, held to the legal range.
    always_comb
    begin
        if (cfg.maze_width < 7'd2)
        begin
            w = WW'(2);
        end
        else if (32'(cfg.maze_width) > MAX_WIDTH)
        begin
            w = WW'(MAX_WIDTH);
        end
        else
        begin
            w = WW'(cfg.maze_width);
        end
        if (cfg.maze_height < 7'd2)
        begin
            h = HW'(2);
        end
        else if (32'(cfg.maze_height) > MAX_HEIGHT)
        begin
            h = HW'(MAX_HEIGHT);
        end
        else
        begin
            h = HW'(cfg.maze_height);
        end
    end

    // Neighbours of the top cell; coordinates that wrap are masked by inb.
    always_comb
    begin
        nbx[DIR_UP]    = top_x_reg;
        nby[DIR_UP]    = top_y_reg - YW'(1);
        nbx[DIR_DOWN]  = top_x_reg;
        nby[DIR_DOWN]  = top_y_reg + YW'(1);
        nbx[DIR_LEFT]  = top_x_reg - XW'(1);
        nby[DIR_LEFT]  = top_y_reg;
        nbx[DIR_RIGHT] = top_x_reg + XW'(1);
        nby[DIR_RIGHT] = top_y_reg;

        inb[DIR_UP]    = (top_y_reg != '0) && (32'(top_y_reg) - 32'd1 < 32'(h))
                         && (32'(top_x_reg) < 32'(w));
        inb[DIR_DOWN]  = (32'(top_y_reg) + 32'd1 < 32'(h)) && (32'(top_x_reg) < 32'(w));
        inb[DIR_LEFT]  = (top_x_reg != '0) && (32'(top_x_reg) - 32'd1 < 32'(w))
                         && (32'(top_y_reg) < 32'(h));
        inb[DIR_RIGHT] = (32'(top_x_reg) + 32'd1 < 32'(w)) && (32'(top_y_reg) < 32'(h));

        for (int k = 0; k < 4; k++)
        begin
            cand[k] = inb[k] && !nb_word_reg[k].visited;
        end
        cand_n = 3'($countones(cand));
        case (cand_n)
            3'd2:    pick = {1'b0, rnd_reg[0]};
            3'd3:    pick = rnd_m3_reg;
            3'd4:    pick = rnd_reg[1:0];
            default: pick = 2'd0;
        endcase
        pick_dir = nth_set(cand, pick);
    end

    assign cnt_m1 = count_reg - CW'(1);
    assign cnt_m2 = count_reg - CW'(2);

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        clr_start_next = clr_start_reg;
        count_next     = count_reg;
        finished_next  = finished_reg;
        probe_next     = probe_reg;
        rnd_next       = rnd_reg;
        rnd_m3_next    = rnd_m3_reg;
        top_x_next     = top_x_reg;
        top_y_next     = top_y_reg;
        top_word_next  = top_word_reg;
        nb_word_next   = nb_word_reg;
        dir_next       = dir_reg;
        res_next       = res_reg;

        cmd_ready  = 1'b0;
        res_valid  = 1'b0;
        cell_we    = 1'b0;
        cell_waddr = '0;
        cell_wdata = '0;
        cell_re    = 1'b0;
        cell_raddr = '0;
        stk_we     = 1'b0;
        stk_waddr  = '0;
        stk_wdata  = '0;
        stk_re     = 1'b0;
        stk_raddr  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    rnd_next    = cmd.random_value;
                    rnd_m3_next = mod3_16(cmd.random_value);
                    res_next    = '0;
                    case (op_t'(cmd.operation))
                        OP_START:
                        begin
                            // The first cell goes on the stack now; the sweep
                            // marks it visited as it passes.
                            stk_we         = 1'b1;
                            stk_waddr      = '0;
                            stk_wdata      = {YW'(1), XW'(0)};
                            count_next     = CW'(1);
                            finished_next  = 1'b0;
                            clr_addr_next  = '0;
                            clr_start_next = 1'b1;
                            state_next     = ST_CLEAR;
                        end
                        OP_STEP:
                        begin
                            if (finished_reg)
                            begin
                                res_next.done_res = 1'b1;
                                state_next        = ST_RESP;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = ST_FIN_A;
                            end
                            else
                            begin
                                stk_re     = 1'b1;
                                stk_raddr  = cnt_m1[AW-1:0];
                                state_next = ST_TOP;
                            end
                        end
                        OP_READ:
                        begin
                            if ((32'(cmd.cell_x) < MAX_WIDTH) && (32'(cmd.cell_y) < MAX_HEIGHT))
                            begin
                                cell_re    = 1'b1;
                                cell_raddr = cell_addr(32'(cmd.cell_x), 32'(cmd.cell_y));
                                state_next = ST_RDWAIT;
                            end
                            else
                            begin
                                res_next.walls    = WALLS_ALL;
                                res_next.done_res = finished_reg;
                                state_next        = ST_RESP;
                            end
                        end
                        default:
                        begin
                            res_next.done_res = finished_reg;
                            state_next        = ST_RESP;
                        end
                    endcase
                end
            end

            ST_CLEAR:
            begin
                cell_we            = 1'b1;
                cell_waddr         = clr_addr_reg;
                cell_wdata.walls   = WALLS_ALL;
                cell_wdata.visited = clr_start_reg && (clr_addr_reg == START_ADDR);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = clr_start_reg ? ST_RESP : ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end

            ST_RDWAIT:
            begin
                res_next.walls        = cell_rdata.walls;
                res_next.cell_visited = cell_rdata.visited;
                res_next.done_res     = finished_reg;
                state_next            = ST_RESP;
            end

            ST_TOP:
            begin
                top_x_next = stk_rdata[XW-1:0];
                top_y_next = stk_rdata[XW +: YW];
                cell_re    = 1'b1;
                cell_raddr = cell_addr(32'(stk_rdata[XW-1:0]), 32'(stk_rdata[XW +: YW]));
                probe_next = 2'd0;
                state_next = ST_PROBE;
            end

            ST_PROBE:
            begin
                // Data returning now belongs to the read issued in the cycle before.
                cell_re    = inb[probe_reg];
                cell_raddr = cell_addr(32'(nbx[probe_reg]), 32'(nby[probe_reg]));
                if (probe_reg == 2'd0)
                begin
                    top_word_next = cell_rdata;
                end
                else
                begin
                    nb_word_next[probe_reg - 2'd1] = cell_rdata;
                end
                if (probe_reg == 2'd3)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    probe_next = probe_reg + 2'd1;
                end
            end

            ST_LAST:
            begin
                nb_word_next[DIR_RIGHT] = cell_rdata;
                state_next              = ST_DECIDE;
            end

            ST_DECIDE:
            begin
                if (cand == 4'b0000)
                begin
                    // Dead end: pop and examine the cell below it.
                    count_next = cnt_m1;
                    if (count_reg == CW'(1))
                    begin
                        state_next = ST_FIN_A;
                    end
                    else
                    begin
                        stk_re     = 1'b1;
                        stk_raddr  = cnt_m2[AW-1:0];
                        state_next = ST_TOP;
                    end
                end
                else
                begin
                    cell_we            = 1'b1;
                    cell_waddr         = cell_addr(32'(nbx[pick_dir]), 32'(nby[pick_dir]));
                    cell_wdata.visited = 1'b1;
                    cell_wdata.walls   = nb_word_reg[pick_dir].walls
                                         & ~wall_bit(opposite(pick_dir));
                    if (32'(count_reg) < CELLS)
                    begin
                        stk_we     = 1'b1;
                        stk_waddr  = count_reg[AW-1:0];
                        stk_wdata  = {nby[pick_dir], nbx[pick_dir]};
                        count_next = count_reg + CW'(1);
                    end
                    dir_next           = pick_dir;
                    res_next.carved    = 1'b1;
                    res_next.from_x    = 6'(top_x_reg);
                    res_next.from_y    = 6'(top_y_reg);
                    res_next.direction = pick_dir;
                    res_next.done_res  = finished_reg;
                    state_next         = ST_WTOP;
                end
            end

            ST_WTOP:
            begin
                cell_we            = 1'b1;
                cell_waddr         = cell_addr(32'(top_x_reg), 32'(top_y_reg));
                cell_wdata.visited = top_word_reg.visited;
                cell_wdata.walls   = top_word_reg.walls & ~wall_bit(dir_reg);
                state_next         = ST_RESP;
            end

            ST_FIN_A:
            begin
                cell_re    = 1'b1;
                cell_raddr = cell_addr(32'(w) - 32'd2, 32'(h) - 32'd1);
                state_next = ST_FIN_B;
            end

            ST_FIN_B:
            begin
                cell_re            = 1'b1;
                cell_raddr         = cell_addr(32'(w) - 32'd1, 32'(h) - 32'd1);
                cell_we            = 1'b1;
                cell_waddr         = cell_addr(32'(w) - 32'd2, 32'(h) - 32'd1);
                cell_wdata.visited = cell_rdata.visited;
                cell_wdata.walls   = cell_rdata.walls & ~wall_bit(DIR_RIGHT);
                state_next         = ST_FIN_C;
            end

            ST_FIN_C:
            begin
                cell_we            = 1'b1;
                cell_waddr         = cell_addr(32'(w) - 32'd1, 32'(h) - 32'd1);
                cell_wdata.visited = cell_rdata.visited;
                cell_wdata.walls   = cell_rdata.walls & ~wall_bit(DIR_LEFT);
                finished_next      = 1'b1;
                res_next.done_res  = 1'b1;
                state_next         = ST_RESP;
            end

            ST_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    // Control state; a reset starts the clearing sweep with no stack push.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            clr_start_reg <= 1'b0;
            count_reg     <= '0;
            finished_reg  <= 1'b0;
            probe_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_start_reg <= clr_start_next;
            count_reg     <= count_next;
            finished_reg  <= finished_next;
            probe_reg     <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg      <= rnd_next;
        rnd_m3_reg   <= rnd_m3_next;
        top_x_reg    <= top_x_next;
        top_y_reg    <= top_y_next;
        top_word_reg <= top_word_next;
        nb_word_reg  <= nb_word_next;
        dir_reg      <= dir_next;
        res_reg      <= res_next;
    end

`ifndef SYNTH
    // The cell store never reads and writes one entry in the same cycle.
    a_no_rw_same_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_we && cell_re) |-> (cell_waddr != cell_raddr))
        else $error("cell store read and write collide");

    // Once the maze is done the path stack is empty.
    a_done_stack_empty: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> (count_reg == '0))
        else $error("finished with cells still on the stack");

    // A carve into the neighbour is always followed by the top-cell write.
    a_carve_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && cell_we) |=> (state_reg == ST_WTOP && cell_we))
        else $error("carve not followed by top-cell update");

    // A push during a carve raises the stack depth by exactly one.
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE && stk_we) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("stack depth wrong after push");
`endif

endmodule

>>> hdl/maze_backtracker_generator.sv
// ============================================================================
// maze_backtracker_generator: depth-first maze carver
// APB size registers, the carving engine and a result output register.
//
//   channel   direction  handshake               beat
//   item      in         item_valid/item_ready   mbg_pkg::in_item_t
//   result    out        result_valid/ready      mbg_pkg::out_item_t
//   apb       in/out     psel/penable/pready     size registers at 0x0, 0x4
//
// A step that carves reads the stack top, reads the top cell and its four
// neighbours one per cycle through the single read port of the cell store,
// then writes the carved neighbour and the top cell; each dead-end cell
// popped on the way repeats the stack-top read and the five cell reads.
// A start sweeps the whole cell store, one entry a cycle; the same sweep
// runs after reset, and no item is taken until it ends.
// The next item is taken while a result beat waits in the output register.
// ============================================================================
module maze_backtracker_generator #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbg_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  mbg_pkg::in_item_t           item,
    output logic                        result_valid,
    input  logic                        result_ready,
    output mbg_pkg::out_item_t          result
);
    import mbg_pkg::*;

    logic [6:0] width_reg,  width_next;
    logic [6:0] height_reg, height_next;
    logic       result_valid_reg, result_valid_next;
    out_item_t  result_reg, result_next;

    cfg_t       cfg;
    logic       eng_res_valid;
    logic       eng_res_ready;
    out_item_t  eng_res;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            if (paddr[2:2] == REG_MAZE_HEIGHT)
            begin
                height_next = pwdata[6:0];
            end
            else
            begin
                width_next = pwdata[6:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2:2] == REG_MAZE_WIDTH)
        begin
            prdata = {25'd0, width_reg};
        end
        else
        begin
            prdata = {25'd0, height_reg};
        end
    end

    assign cfg.maze_width  = width_reg;
    assign cfg.maze_height = height_reg;

    mbg_engine #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (item_valid),
        .cmd_ready (item_ready),
        .cmd       (item),
        .res_valid (eng_res_valid),
        .res_ready (eng_res_ready),
        .res       (eng_res)
    );

    // The output register takes a new beat whenever it is empty or draining.
    assign eng_res_ready = !result_valid_reg || result_ready;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (eng_res_valid && eng_res_ready)
        begin
            result_valid_next = 1'b1;
            result_next       = eng_res;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg        <= SIZE_RESET;
            height_reg       <= SIZE_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg        <= width_next;
            height_reg       <= height_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
